// ----- sv/frb_pkg.sv -----
// Shared types and codes for the frame ring buffer.
package frb_pkg;

    // Command codes carried in the input word.
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_DRAIN = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_FRAME = 1'd1;

    // Register values after reset.
    localparam logic [4:0]  FRAMES_IN_USE_RST     = 5'd16;
    localparam logic [10:0] SAMPLES_PER_FRAME_RST = 11'd1024;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [15:0]  sample_in;
        logic                frame_end;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0]  sample_out;
        logic                frame_last;
        logic                store_last;
    } t_out_word;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic push;
        logic drain;
        logic clear;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic held_zero;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/frb_ctrl.sv -----
// Sequencer for the frame ring buffer: decodes words and paces drain reads.
module frb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_command,
    input  frb_pkg::t_dp_status   i_status,
    output logic                  o_in_stall,
    output frb_pkg::t_dp_cmd      o_cmd
);

    frb_pkg::t_state r_state;
    frb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b0;
        o_cmd      = '0;
        case (r_state)
            frb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        frb_pkg::CMD_PUSH: begin
                            o_cmd.push = 1'b1;
                        end
                        frb_pkg::CMD_DRAIN: begin
                            // drain of an empty store is taken and dropped
                            if (!i_status.held_zero) begin
                                o_cmd.drain = 1'b1;
                                n_state     = frb_pkg::ST_READ;
                            end
                        end
                        frb_pkg::CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            frb_pkg::ST_READ: begin
                // hold input until the read word lands in the output register
                o_in_stall = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = frb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = frb_pkg::ST_IDLE;
            end
        endcase
    end

    a_drain_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drain |=> (r_state == frb_pkg::ST_READ))
        else $error("drain did not enter read state");

    a_no_load_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frb_pkg::ST_IDLE) |-> !o_cmd.load_out)
        else $error("output load issued outside read state");

    a_stall_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drain |=> o_in_stall)
        else $error("input not stalled during drain read");

endmodule

// ----- sv/frb_datapath.sv -----
// Datapath of the frame ring buffer: pointers, sample and length memories, output register.
module frb_datapath #(
    parameter int MAX_FRAMES        = 16,
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  frb_pkg::t_in_word                 i_in_word,
    input  frb_pkg::t_dp_cmd                  i_cmd,
    output frb_pkg::t_dp_status               o_status,
    input  logic                              i_cfg_wr_en,
    input  logic [frb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [frb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output frb_pkg::t_out_word                o_out_word
);

    localparam int FW    = $clog2(MAX_FRAMES);
    localparam int HW    = $clog2(MAX_FRAMES + 1);
    localparam int OW    = HW + 1;
    localparam int PW    = $clog2(MAX_FRAME_SAMPLES);
    localparam int PCW   = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int DEPTH = 1 << (FW + PW);

    function automatic logic [HW-1:0] clamp_cap(input logic [4:0] v);
        logic [HW-1:0] r;
        if (v == 5'd0) r = HW'(1);
        else if (int'(v) > MAX_FRAMES) r = HW'(MAX_FRAMES);
        else r = HW'(v);
        return r;
    endfunction

    function automatic logic [PCW-1:0] clamp_size(input logic [10:0] v);
        logic [PCW-1:0] r;
        if (v == 11'd0) r = PCW'(1);
        else if (int'(v) > MAX_FRAME_SAMPLES) r = PCW'(MAX_FRAME_SAMPLES);
        else r = PCW'(v);
        return r;
    endfunction

    logic signed [15:0] mem_sample [DEPTH];
    logic [PCW-1:0]     mem_len    [MAX_FRAMES];

    logic [HW-1:0]  r_cap,  n_cap;
    logic [PCW-1:0] r_size, n_size;
    logic [FW-1:0]  r_head, n_head;
    logic [HW-1:0]  r_held, n_held;
    logic [PCW-1:0] r_wp,   n_wp;
    logic [PW-1:0]  r_dp,   n_dp;
    logic           r_out_valid, n_out_valid;

    logic [PW-1:0]      r_rd_pos;
    logic               r_rd_flast;
    logic               r_rd_slast;
    logic signed [15:0] r_rd_data;
    logic [PCW-1:0]     r_rd_len;
    frb_pkg::t_out_word r_out;

    logic           room;
    logic [PCW-1:0] wp_inc;
    logic [HW-1:0]  held_drop;
    logic [OW-1:0]  old_sum;
    logic [OW-1:0]  old_wrap;
    logic [FW-1:0]  oldest;
    logic           flast;
    logic           cfg_hit;

    assign room   = r_wp < r_size;
    assign wp_inc = room ? r_wp + PCW'(1) : r_wp;
    assign held_drop = (r_wp == '0 && r_held >= r_cap) ? r_cap - HW'(1) : r_held;

    // oldest slot: head minus frames held, modulo the capacity
    assign old_sum  = OW'(r_head) + OW'(r_cap) - OW'(r_held);
    assign old_wrap = (old_sum >= OW'(r_cap)) ? old_sum - OW'(r_cap) : old_sum;
    assign oldest   = old_wrap[FW-1:0];

    assign flast = (PCW'(r_dp) + PCW'(1)) >= r_size;

    always_comb begin
        cfg_hit = 1'b0;
        n_cap   = r_cap;
        n_size  = r_size;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                frb_pkg::CFG_FRAMES_IN_USE: begin
                    n_cap   = clamp_cap(i_cfg_data[4:0]);
                    cfg_hit = 1'b1;
                end
                frb_pkg::CFG_SAMPLES_PER_FRAME: begin
                    n_size  = clamp_size(i_cfg_data);
                    cfg_hit = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_head = r_head;
        n_held = r_held;
        n_wp   = r_wp;
        n_dp   = r_dp;
        if (i_cmd.push) begin
            if (r_wp == '0 && r_held >= r_cap) begin
                n_dp = '0;
            end
            if (i_in_word.frame_end) begin
                n_head = (HW'(r_head) + HW'(1) == r_cap) ? '0 : r_head + FW'(1);
                n_held = (held_drop < r_cap) ? held_drop + HW'(1) : held_drop;
                n_wp   = '0;
            end else begin
                n_held = held_drop;
                n_wp   = wp_inc;
            end
        end else if (i_cmd.drain) begin
            if (flast) begin
                n_held = r_held - HW'(1);
                n_dp   = '0;
            end else begin
                n_dp   = r_dp + PW'(1);
            end
        end
        if (i_cmd.clear || cfg_hit) begin
            n_head = '0;
            n_held = '0;
            n_wp   = '0;
            n_dp   = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= clamp_cap(frb_pkg::FRAMES_IN_USE_RST);
            r_size      <= clamp_size(frb_pkg::SAMPLES_PER_FRAME_RST);
            r_head      <= '0;
            r_held      <= '0;
            r_wp        <= '0;
            r_dp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap       <= n_cap;
            r_size      <= n_size;
            r_head      <= n_head;
            r_held      <= n_held;
            r_wp        <= n_wp;
            r_dp        <= n_dp;
            r_out_valid <= n_out_valid;
        end
    end

    // sample and length memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && room) begin
            mem_sample[{r_head, r_wp[PW-1:0]}] <= i_in_word.sample_in;
        end
        if (i_cmd.drain) begin
            r_rd_data <= mem_sample[{oldest, r_dp}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && i_in_word.frame_end) begin
            mem_len[r_head] <= wp_inc;
        end
        if (i_cmd.drain) begin
            r_rd_len <= mem_len[oldest];
        end
    end

    // capture drain position and flags with the read
    always_ff @(posedge i_clk) begin
        if (i_cmd.drain) begin
            r_rd_pos   <= r_dp;
            r_rd_flast <= flast;
            r_rd_slast <= flast && (r_held == HW'(1));
        end
        if (i_cmd.load_out) begin
            r_out.sample_out <= (PCW'(r_rd_pos) < r_rd_len) ? r_rd_data : 16'sd0;
            r_out.frame_last <= r_rd_flast;
            r_out.store_last <= r_rd_slast;
        end
    end

    assign o_status.held_zero = (r_held == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_word         = r_out;

    a_held_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_cap)
        else $error("frame count above capacity");

    a_head_lt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HW'(r_head) < r_cap)
        else $error("head slot outside ring");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= r_size) && (PCW'(r_dp) < r_size))
        else $error("write or drain position past frame size");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

endmodule

// ----- sv/frame_ring_buffer_overwrite_oldest_top.sv -----
// Top level of the frame ring buffer that overwrites the oldest frame when full.
//
// Input channel (i_in_valid / o_in_stall / i_in_word): one word per command.
//   Push writes a sample into the frame at the head; frame_end closes it.
//   Drain reads one sample of the oldest frame; clear empties the store.
// Output channel (o_out_valid / i_out_stall / o_out_word): one word per
//   drain of a non-empty store, with frame_last and store_last flags.
// Push, clear and drain of an empty store never stall the input. A drain
//   stalls the input while the sample memory read is registered; the word
//   then passes from the read register into the output register, which
//   drives o_out_valid.
// The output register parts the channels: a push or clear is taken while a
//   word waits; a drain waits in its read cycle while the receiver stalls.
// Configuration (i_cfg_wr_en / i_cfg_index / i_cfg_data): index 0 sets the
//   frames in use, index 1 the samples per frame; either write empties the
//   store. Write only while the block is idle.
// Reset (synchronous, active low): store empty, 16 frames of 1024 samples,
//   clamped to the built maximum. Memories hold no reset value and need none.
module frame_ring_buffer_overwrite_oldest_top #(
    parameter int MAX_FRAMES        = 16,
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  frb_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output frb_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_wr_en,
    input  logic [frb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [frb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    frb_pkg::t_dp_cmd    cmd;
    frb_pkg::t_dp_status status;

    // Decode words and sequence the drain read.
    frb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_word.command),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold the ring pointers, memories and the output register.
    frb_datapath #(
        .MAX_FRAMES        (MAX_FRAMES),
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
